FILE: rtl/pste_pkg.sv
package pste_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int AXES             = 3;
  localparam int COEFFS           = 8;
  localparam int BOUND_ORDERS     = 4;
  localparam int BND_HALF         = BOUND_ORDERS * AXES;
  localparam int BND_DEPTH        = 2 * BND_HALF;
  localparam int VAL_W            = 32;
  localparam int DIV_W            = 64;
  localparam int DVS_W            = 31;
  localparam int TOT_W            = 36;

  typedef enum logic [1:0] {
    OP_COEF = 2'd0,
    OP_DUR  = 2'd1,
    OP_BND  = 2'd2,
    OP_EVAL = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_IDX  = 2'd1;
  localparam logic [1:0] ST_ZERO_DUR = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  // falling factorial p*(p-1)*...*(p-k+1), k <= p <= 7
  function automatic logic [12:0] fall(input logic [2:0] p, input logic [2:0] k);
    logic [12:0] r;
    r = 13'd1;
    for (int i = 0; i < 7; i++) begin
      if (i < int'(k)) r = 13'(r * 13'(int'(p) - i));
    end
    return r;
  endfunction

endpackage

FILE: rtl/pste_ifs.sv
interface pste_in_if;
  import pste_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [3:0]              segment_index;
  logic [1:0]              axis_index;
  logic [3:0]              order_index;
  logic                    end_select;
  logic signed [VAL_W-1:0] load_value;
  logic signed [VAL_W-1:0] eval_time;
  modport source (output valid, op, segment_index, axis_index, order_index, end_select,
                  load_value, eval_time, input ready);
  modport sink (input valid, op, segment_index, axis_index, order_index, end_select,
                load_value, eval_time, output ready);
endinterface

interface pste_out_if;
  import pste_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_x;
  logic signed [VAL_W-1:0] value_y;
  logic signed [VAL_W-1:0] value_z;
  logic [1:0]              status;
  modport source (output valid, value_x, value_y, value_z, status, input ready);
  modport sink (input valid, value_x, value_y, value_z, status, output ready);
endinterface

FILE: rtl/pste_div.sv
module pste_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pste_pkg::DIV_W-1:0]    dividend,
  input  logic [pste_pkg::DVS_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [pste_pkg::DIV_W-1:0]    quotient
);
  import pste_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], qbit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/piecewise_septic_trajectory_evaluator.sv
// Piecewise 7th-degree trajectory evaluator, three axes, Q16.16.
// Input channel in_ch (valid/ready) carries one request: a coefficient,
// duration or boundary load, or an evaluate at eval_time for derivative
// order order_index. Every request gives exactly one response on out_ch.
// cfg_we/cfg_wdata set the number of segments in use (reset value 1); write
// it only while no request is in flight.
// Loads with a valid index write the memories at acceptance; loads go straight to S_OUT.
// Evaluate runs one request at a time through a sequencer around the
// coefficient memory and the duration/boundary memory (one read per cycle):
//   summing the durations of the segments in use, a pick step, then either
//   boundary reads for the three axes, or the segment walk, the normalized
//   time divide, the term loop and the derivative scaling; both divides use
//   the shared 64-step serial divider.
// Orders 8 and above skip the sequencer and answer with zeros.
// A finished response sits in an output register; while it waits for
// out_ch.ready the next request may already be accepted, and the one after
// that waits. Reset clears the control state only; the memories hold
// garbage until loaded.
module piecewise_septic_trajectory_evaluator #(
  parameter int MAX_SEGMENTS = pste_pkg::MAX_SEGMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pste_in_if.sink    in_ch,
  pste_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);
  import pste_pkg::*;

  localparam int CDEPTH = MAX_SEGMENTS * AXES * COEFFS;
  localparam int ADEPTH = BND_DEPTH + MAX_SEGMENTS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int AAW    = $clog2(ADEPTH);
  localparam logic signed [63:0] GROW = 64'sd1 <<< 47;
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
  localparam logic [30:0] UONE = 31'd1 << 30;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_TOT   = 11'b00000000010,
    S_PICK  = 11'b00000000100,
    S_BND   = 11'b00000001000,
    S_WALK  = 11'b00000010000,
    S_LOC   = 11'b00000100000,
    S_UDIV  = 11'b00001000000,
    S_TERM  = 11'b00010000000,
    S_POW   = 11'b00100000000,
    S_SCALE = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [VAL_W-1:0] coef_mem [CDEPTH];
  logic [VAL_W-1:0] aux_mem  [ADEPTH];   // boundaries first, then durations
  logic [VAL_W-1:0] coef_q_r, aux_q_r;
  logic [CAW-1:0]   coef_waddr, coef_raddr;
  logic [AAW-1:0]   aux_waddr, aux_raddr;
  logic             coef_we, aux_we;

  logic [4:0]  segs_r, n_m1;
  logic        in_acc, out_free;
  op_t         op_in;
  logic        seg_bad;
  logic [1:0]  load_st;

  logic [2:0]  k_r, p_r, i_r;
  logic [1:0]  ax_r, sub_r;
  logic        phase_r, bsel_r, neg_r;
  logic [4:0]  cnt_r, seg_r;
  logic signed [VAL_W-1:0] time_r;
  logic [TOT_W-1:0] total_r, cum_r, t_r, start_r, t_c, cum_n, loc_d;
  logic [VAL_W-1:0] dur_r;
  logic        d_bad;
  logic [30:0] loc_c, u_r, pw_r;
  logic [61:0] pmul_r;
  logic signed [63:0] m_r, m_b;
  logic signed [33:0] q_w;
  logic signed [47:0] f_r;
  logic signed [63:0] s_r [AXES];
  logic        sat_r [AXES];
  logic [1:0]  st_r;
  logic        big;

  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_dividend, div_quo;
  logic [DVS_W-1:0]  div_divisor;
  logic [63:0]       s_mag;

  logic signed [VAL_W-1:0] res_w [AXES];
  logic        any_sat;
  logic signed [VAL_W-1:0] vx_r, vy_r, vz_r;
  logic [1:0]  ost_r;
  logic        out_valid_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign op_in    = op_t'(in_ch.op);
  assign seg_bad  = (32'(in_ch.segment_index) >= MAX_SEGMENTS);

  always_comb begin
    if (segs_r == 5'd0)                     n_m1 = 5'd0;
    else if (32'(segs_r) > MAX_SEGMENTS)    n_m1 = 5'(MAX_SEGMENTS - 1);
    else                                    n_m1 = segs_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) segs_r <= 5'd1;
    else if (cfg_we) segs_r <= cfg_wdata;
  end

  // load decode
  always_comb begin
    load_st   = ST_OK;
    coef_we   = 1'b0;
    aux_we    = 1'b0;
    coef_waddr = CAW'((CAW'(in_ch.segment_index) * CAW'(AXES) + CAW'(in_ch.axis_index))
                      * CAW'(COEFFS) + CAW'(in_ch.order_index[2:0]));
    aux_waddr = AAW'(BND_DEPTH) + AAW'(in_ch.segment_index);
    unique case (op_in)
      OP_COEF: begin
        if (seg_bad || in_ch.axis_index == 2'd3 || in_ch.order_index[3]) load_st = ST_BAD_IDX;
        else coef_we = in_acc;
      end
      OP_DUR: begin
        if (seg_bad) load_st = ST_BAD_IDX;
        else if (in_ch.load_value <= 0) load_st = ST_ZERO_DUR;
        else aux_we = in_acc;
      end
      OP_BND: begin
        aux_waddr = AAW'((in_ch.end_select ? BND_HALF : 0)
                         + int'(in_ch.order_index[1:0]) * AXES + int'(in_ch.axis_index));
        if (in_ch.axis_index == 2'd3 || in_ch.order_index[3:2] != 2'd0) load_st = ST_BAD_IDX;
        else aux_we = in_acc;
      end
      OP_EVAL: load_st = ST_OK;
      default: load_st = ST_OK;
    endcase
  end

  assign coef_raddr = CAW'((CAW'(seg_r) * CAW'(AXES) + CAW'(ax_r)) * CAW'(COEFFS)
                           + CAW'(p_r));
  assign aux_raddr  = (state_r == S_BND)
                      ? AAW'((bsel_r ? BND_HALF : 0) + int'(k_r) * AXES + int'(ax_r))
                      : AAW'(BND_DEPTH) + AAW'(cnt_r);

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= in_ch.load_value;
    coef_q_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (aux_we) aux_mem[aux_waddr] <= in_ch.load_value;
    aux_q_r <= aux_mem[aux_raddr];
  end

  // datapath helpers
  always_comb begin
    if (time_r[VAL_W-1])                         t_c = '0;
    else if (TOT_W'(time_r[VAL_W-2:0]) > total_r) t_c = total_r;
    else                                         t_c = TOT_W'(time_r[VAL_W-2:0]);
    cum_n = cum_r + TOT_W'(aux_q_r[30:0]);
    d_bad = dur_r[VAL_W-1] || (dur_r == '0);
    loc_d = t_r - start_r;
    loc_c = (loc_d > TOT_W'(dur_r[30:0])) ? dur_r[30:0] : loc_d[30:0];
    // truncate toward zero on the divide by 2^30
    m_b   = m_r + (m_r[63] ? 64'sd1073741823 : 64'sd0);
    q_w   = m_b[63:30];
    big   = (s_r[ax_r] >= GROW) || (s_r[ax_r] <= -GROW);
    s_mag = s_r[ax_r][63] ? 64'(-s_r[ax_r]) : 64'(s_r[ax_r]);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {3'b000, loc_c, 30'd0};
    div_divisor  = dur_r[30:0];
    if (state_r == S_LOC && !d_bad) div_start = 1'b1;
    if (state_r == S_SCALE && !phase_r && !big) begin
      div_start    = 1'b1;
      div_dividend = {s_mag[47:0], 16'd0};
    end
  end

  pste_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (op_in == OP_EVAL && !in_ch.order_index[3]) ? S_TOT : S_OUT;
      S_TOT:   if (phase_r && cnt_r == n_m1) state_nxt = S_PICK;
      S_PICK:  state_nxt = (!k_r[2] && (t_c == '0 || t_c >= total_r)) ? S_BND : S_WALK;
      S_BND:   if (phase_r && ax_r == 2'd2) state_nxt = S_OUT;
      S_WALK:  if (phase_r && (t_r <= cum_n || cnt_r == n_m1)) state_nxt = S_LOC;
      S_LOC:   state_nxt = d_bad ? S_OUT : S_UDIV;
      S_UDIV:  if (div_done) state_nxt = S_TERM;
      S_TERM:  begin
        if (sub_r == 2'd3 && ax_r == 2'd2) begin
          if (p_r != 3'd7)       state_nxt = S_POW;
          else if (k_r == 3'd0)  state_nxt = S_OUT;
          else                   state_nxt = S_SCALE;
        end
      end
      S_POW:   if (phase_r) state_nxt = S_TERM;
      S_SCALE: begin
        if (ax_r == 2'd2 && ((!phase_r && big) || (phase_r && div_done && i_r == k_r - 3'd1)))
          state_nxt = S_OUT;
      end
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_r    <= (op_in == OP_EVAL) ? ST_OK : load_st;
          k_r     <= in_ch.order_index[2:0];
          time_r  <= in_ch.eval_time;
          total_r <= '0;
          cum_r   <= '0;
          cnt_r   <= '0;
          phase_r <= 1'b0;
          for (int a = 0; a < AXES; a++) begin
            s_r[a]   <= '0;
            sat_r[a] <= 1'b0;
          end
        end
      end
      S_TOT: begin
        phase_r <= !phase_r;
        if (phase_r) begin
          total_r <= total_r + TOT_W'(aux_q_r[30:0]);
          cnt_r   <= (cnt_r == n_m1) ? 5'd0 : cnt_r + 5'd1;
        end
      end
      S_PICK: begin
        t_r     <= t_c;
        bsel_r  <= (t_c != '0);
        ax_r    <= '0;
        phase_r <= 1'b0;
      end
      S_BND: begin
        phase_r <= !phase_r;
        if (phase_r) begin
          s_r[ax_r] <= 64'($signed(aux_q_r));
          ax_r      <= ax_r + 2'd1;
        end
      end
      S_WALK: begin
        phase_r <= !phase_r;
        if (phase_r) begin
          if (t_r <= cum_n || cnt_r == n_m1) begin
            seg_r   <= cnt_r;
            dur_r   <= aux_q_r;
            start_r <= cum_r;
          end else begin
            cum_r <= cum_n;
            cnt_r <= cnt_r + 5'd1;
          end
        end
      end
      S_LOC: begin
        if (d_bad) st_r <= ST_ZERO_DUR;
      end
      S_UDIV: begin
        if (div_done) begin
          u_r   <= div_quo[30:0];
          pw_r  <= UONE;
          p_r   <= k_r;
          ax_r  <= '0;
          sub_r <= '0;
        end
      end
      S_TERM: begin
        sub_r <= sub_r + 2'd1;
        case (sub_r)
          2'd1: m_r <= $signed(coef_q_r) * $signed({1'b0, pw_r});
          2'd2: f_r <= q_w * $signed({1'b0, fall(p_r, k_r)});
          2'd3: begin
            s_r[ax_r] <= s_r[ax_r] + 64'(f_r);
            ax_r      <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
            phase_r   <= 1'b0;
            i_r       <= '0;
          end
          default: ;
        endcase
      end
      S_POW: begin
        phase_r <= !phase_r;
        if (!phase_r) pmul_r <= pw_r * u_r;
        else begin
          pw_r <= pmul_r[60:30];
          p_r  <= p_r + 3'd1;
        end
      end
      S_SCALE: begin
        if (!phase_r) begin
          if (big) begin
            sat_r[ax_r] <= 1'b1;
            ax_r        <= ax_r + 2'd1;
            i_r         <= '0;
          end else begin
            neg_r   <= s_r[ax_r][63];
            phase_r <= 1'b1;
          end
        end else if (div_done) begin
          s_r[ax_r] <= neg_r ? -$signed(div_quo) : $signed(div_quo);
          phase_r   <= 1'b0;
          if (i_r == k_r - 3'd1) begin
            i_r  <= '0;
            ax_r <= ax_r + 2'd1;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // final saturation to 32 bits
  always_comb begin
    any_sat = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (sat_r[a] || s_r[a] > I32_MAX || s_r[a] < I32_MIN) begin
        any_sat  = 1'b1;
        res_w[a] = s_r[a][63] ? VAL_W'(I32_MIN) : VAL_W'(I32_MAX);
      end else begin
        res_w[a] = VAL_W'(s_r[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      vx_r  <= res_w[0];
      vy_r  <= res_w[1];
      vz_r  <= res_w[2];
      ost_r <= (st_r == ST_OK && any_sat) ? ST_SAT : st_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.value_x = vx_r;
  assign out_ch.value_y = vy_r;
  assign out_ch.value_z = vz_r;
  assign out_ch.status  = ost_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after a request");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_u_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TERM |-> u_r <= UONE)
    else $error("normalized time above one");

  a_zero_dur_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ost_r == ST_ZERO_DUR |-> vx_r == 0 && vy_r == 0 && vz_r == 0)
    else $error("zero duration response carries data");

endmodule
